### src/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kind codes, scan modes and character class helpers.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int unsigned MaxNumberLength = 128;

   localparam logic [5:0] KIND_ID      = 6'd0;
   localparam logic [5:0] KIND_NUMBER  = 6'd1;
   localparam logic [5:0] KIND_KW_BASE = 6'd2;
   localparam logic [5:0] KIND_INC     = 6'd17;
   localparam logic [5:0] KIND_DEC     = 6'd18;
   localparam logic [5:0] KIND_ARROW_R = 6'd41;
   localparam logic [5:0] KIND_ARROW_L = 6'd42;
   localparam logic [5:0] KIND_END     = 6'd45;
   localparam logic [5:0] KIND_UNKNOWN = 6'd46;

   // operator slots; pend_ff holds one of these
   localparam logic [3:0] OP_PLUS  = 4'd0;
   localparam logic [3:0] OP_MINUS = 4'd1;
   localparam logic [3:0] OP_LT    = 4'd9;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_OPER   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] line;
      logic [15:0] col;
      logic [7:0]  len;
   } token_type;

   function automatic logic is_alpha_us(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hffff) ? v : v + 16'd1;
   endfunction

   // returns operator slot; valid flag in bit 4
   function automatic logic [4:0] op_index(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      unique case (c)
         8'h2b: r = 5'h10;
         8'h2d: r = 5'h11;
         8'h2a: r = 5'h12;
         8'h2f: r = 5'h13;
         8'h25: r = 5'h14;
         8'h5e: r = 5'h15;
         8'h3d: r = 5'h16;
         8'h21: r = 5'h17;
         8'h7e: r = 5'h18;
         8'h3c: r = 5'h19;
         8'h3e: r = 5'h1a;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] op_single(input logic [3:0] i);
      logic [5:0] k;
      unique case (i)
         4'd0: k = 6'd10;
         4'd1: k = 6'd11;
         4'd2: k = 6'd12;
         4'd3: k = 6'd13;
         4'd4: k = 6'd14;
         4'd5: k = 6'd15;
         4'd6: k = 6'd27;
         4'd7: k = 6'd19;
         4'd8: k = 6'd21;
         4'd9: k = 6'd23;
         default: k = 6'd25;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] op_eq(input logic [3:0] i);
      logic [5:0] k;
      unique case (i)
         4'd0: k = 6'd28;
         4'd1: k = 6'd29;
         4'd2: k = 6'd30;
         4'd3: k = 6'd31;
         4'd4: k = 6'd32;
         4'd5: k = 6'd33;
         4'd6: k = 6'd16;
         4'd7: k = 6'd20;
         4'd8: k = 6'd22;
         4'd9: k = 6'd24;
         default: k = 6'd26;
      endcase
      return k;
   endfunction

   // punctuation kind; valid flag in bit 6
   function automatic logic [6:0] punct_kind(input logic [7:0] c);
      logic [6:0] r;
      unique case (c)
         8'h28: r = {1'b1, 6'd34};
         8'h29: r = {1'b1, 6'd35};
         8'h5b: r = {1'b1, 6'd36};
         8'h5d: r = {1'b1, 6'd37};
         8'h7b: r = {1'b1, 6'd38};
         8'h7d: r = {1'b1, 6'd39};
         8'h2c: r = {1'b1, 6'd43};
         8'h3b: r = {1'b1, 6'd44};
         8'h3a: r = {1'b1, 6'd40};
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] keyword_kind(input logic [47:0] buf_v, input logic [7:0] len);
      logic [5:0] k;
      k = KIND_ID;
      if (len == 8'd6 && buf_v == 48'h72657475726e) k = KIND_KW_BASE;
      if (len == 8'd2 && buf_v == 48'h6966)         k = KIND_KW_BASE + 6'd1;
      if (len == 8'd5 && buf_v == 48'h7768696c65)   k = KIND_KW_BASE + 6'd2;
      if (len == 8'd3 && buf_v == 48'h666f72)       k = KIND_KW_BASE + 6'd3;
      if (len == 8'd2 && buf_v == 48'h666e)         k = KIND_KW_BASE + 6'd4;
      if (len == 8'd3 && buf_v == 48'h766172)       k = KIND_KW_BASE + 6'd5;
      if (len == 8'd3 && buf_v == 48'h6c6574)       k = KIND_KW_BASE + 6'd6;
      if (len == 8'd5 && buf_v == 48'h636f6e7374)   k = KIND_KW_BASE + 6'd7;
      return k;
   endfunction

endpackage

### src/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexical analyzer
// One source byte per item in, tokens with kind and position out.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one byte per item; req_tuser set marks end of input,
//   which flushes the pending token, emits an end token and restarts.
//   rsp_ channel carries tokens; rsp_tlast marks the last token an item caused.
//   An item causes zero, one or two tokens.
// Timing:
//   Tokens of an item appear in the cycle after it is accepted. One item per
//   cycle is sustained while items cause at most one token and rsp_tready
//   stays high; an item with two tokens holds the input while the pair drains.
//   The scanner state update is a single registered step per byte.
// Reset:
//   Synchronous; clears scan state, line and column, drops held results.
// Stall:
//   When rsp_tready is low, held tokens stay and req_tready drops once the
//   result registers cannot take another item's tokens.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
   parameter int unsigned MAX_NUMBER_LENGTH = stt_pkg::MaxNumberLength
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [5:0] token_kind, [21:6] line_number,
                                    // [37:22] column, [45:38] lexeme_length
   output logic        rsp_tlast    // last_of_run
);
   logic               step;
   logic               can_load;
   logic [1:0]         tok_count;
   stt_pkg::token_type tok0, tok1;

   assign req_tready = can_load;
   assign step = req_tvalid && req_tready;

   stt_scan #(.MAX_NUMBER_LENGTH(MAX_NUMBER_LENGTH)) u_scan (
      .clock(clock), .reset(reset), .step(step),
      .char_code(req_tdata), .end_of_input(req_tuser),
      .tok_count(tok_count), .tok0(tok0), .tok1(tok1)
   );

   stt_out u_out (
      .clock(clock), .reset(reset), .load(step && tok_count != 2'd0),
      .tok_count(tok_count), .tok0(tok0), .tok1(tok1), .can_load(can_load),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );
endmodule

### src/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan: scanner state and next-token logic
// Holds the scan state and produces up to two tokens for each item.
// ----------------------------------------------------------------------------
module stt_scan #(
   parameter int unsigned MAX_NUMBER_LENGTH = stt_pkg::MaxNumberLength
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          char_code,
   input  logic                end_of_input,
   output logic [1:0]          tok_count,
   output stt_pkg::token_type  tok0,
   output stt_pkg::token_type  tok1
);
   localparam logic [7:0] NumMax = 8'(MAX_NUMBER_LENGTH);

   stt_pkg::mode_type mode_ff, mode_in;
   logic [3:0]  pend_ff, pend_in;
   logic [47:0] kbuf_ff, kbuf_in;
   logic [7:0]  len_ff, len_in;
   logic        dot_ff, dot_in;
   logic [15:0] line_ff, line_in, col_ff, col_in;
   logic [31:0] start_ff, start_in;

   always_comb begin
      logic       flush_en, begin_en;
      logic [4:0] opi;
      logic [6:0] pk;
      logic [5:0] sk;
      logic       sk_ok;
      stt_pkg::token_type t;
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      kbuf_in  = kbuf_ff;
      len_in   = len_ff;
      dot_in   = dot_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      start_in = start_ff;
      tok_count = 2'd0;
      tok0 = '0;
      tok1 = '0;
      flush_en = 1'b0;
      begin_en = 1'b0;
      opi = stt_pkg::op_index(char_code);
      pk  = stt_pkg::punct_kind(char_code);
      sk_ok = 1'b1;
      if (char_code == 8'h3d) sk = stt_pkg::op_eq(pend_ff);
      else if (pend_ff == stt_pkg::OP_PLUS && char_code == 8'h2b) sk = stt_pkg::KIND_INC;
      else if (pend_ff == stt_pkg::OP_MINUS && char_code == 8'h2d) sk = stt_pkg::KIND_DEC;
      else if (pend_ff == stt_pkg::OP_MINUS && char_code == 8'h3e)
         sk = stt_pkg::KIND_ARROW_R;
      else if (pend_ff == stt_pkg::OP_LT && char_code == 8'h2d) sk = stt_pkg::KIND_ARROW_L;
      else begin
         sk = '0;
         sk_ok = 1'b0;
      end

      unique case (mode_ff)
         stt_pkg::MODE_IDENT: begin
            if (!end_of_input &&
                (stt_pkg::is_alpha_us(char_code) || stt_pkg::is_digit(char_code))) begin
               if (len_ff != 8'hff) len_in = len_ff + 8'd1;
               if (len_ff < 8'd6) kbuf_in = {kbuf_ff[39:0], char_code};
               col_in = stt_pkg::sat_inc(col_ff);
            end else begin
               flush_en = 1'b1;
            end
         end
         stt_pkg::MODE_NUMBER: begin
            if (!end_of_input && len_ff < NumMax &&
                (stt_pkg::is_digit(char_code) || (char_code == 8'h2e && !dot_ff))) begin
               if (char_code == 8'h2e) dot_in = 1'b1;
               len_in = len_ff + 8'd1;
               col_in = stt_pkg::sat_inc(col_ff);
            end else begin
               flush_en = 1'b1;
            end
         end
         stt_pkg::MODE_OPER: begin
            if (!end_of_input && sk_ok) begin
               tok0 = '{sk, start_ff[31:16], start_ff[15:0], 8'd2};
               tok_count = 2'd1;
               col_in = stt_pkg::sat_inc(col_ff);
               mode_in = stt_pkg::MODE_IDLE;
            end else begin
               flush_en = 1'b1;
            end
         end
         default: ;
      endcase

      t.line = start_ff[31:16];
      t.col  = start_ff[15:0];
      t.len  = (mode_ff == stt_pkg::MODE_OPER) ? 8'd1 : len_ff;
      unique case (mode_ff)
         stt_pkg::MODE_IDENT:  t.kind = stt_pkg::keyword_kind(kbuf_ff, len_ff);
         stt_pkg::MODE_NUMBER: t.kind = stt_pkg::KIND_NUMBER;
         default:              t.kind = stt_pkg::op_single(pend_ff);
      endcase
      if (flush_en) begin
         tok0 = t;
         tok_count = 2'd1;
         mode_in = stt_pkg::MODE_IDLE;
      end
      begin_en = !end_of_input && (flush_en || mode_ff == stt_pkg::MODE_IDLE);

      if (end_of_input) begin
         t = '{stt_pkg::KIND_END, line_ff, col_ff, 8'd0};
         if (tok_count == 2'd0) tok0 = t;
         else tok1 = t;
         tok_count = tok_count + 2'd1;
         mode_in  = stt_pkg::MODE_IDLE;
         pend_in  = '0;
         kbuf_in  = '0;
         len_in   = '0;
         dot_in   = 1'b0;
         line_in  = '0;
         col_in   = '0;
         start_in = '0;
      end else if (begin_en) begin
         if (char_code == 8'h20 || (char_code >= 8'd9 && char_code <= 8'd13)) begin
            if (char_code == 8'h0a) begin
               line_in = stt_pkg::sat_inc(line_ff);
               col_in = '0;
            end else begin
               col_in = stt_pkg::sat_inc(col_ff);
            end
         end else begin
            start_in = {line_ff, col_ff};
            col_in = stt_pkg::sat_inc(col_ff);
            t.line = line_ff;
            t.col  = col_ff;
            t.len  = 8'd1;
            t.kind = pk[6] ? pk[5:0] : stt_pkg::KIND_UNKNOWN;
            if (stt_pkg::is_alpha_us(char_code)) begin
               mode_in = stt_pkg::MODE_IDENT;
               len_in = 8'd1;
               kbuf_in = {40'd0, char_code};
            end else if (stt_pkg::is_digit(char_code) || char_code == 8'h2e) begin
               mode_in = stt_pkg::MODE_NUMBER;
               len_in = 8'd1;
               dot_in = (char_code == 8'h2e);
            end else if (opi[4]) begin
               mode_in = stt_pkg::MODE_OPER;
               pend_in = opi[3:0];
               len_in = 8'd1;
            end else begin
               if (tok_count == 2'd0) tok0 = t;
               else tok1 = t;
               tok_count = tok_count + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stt_pkg::MODE_IDLE;
         pend_ff  <= '0;
         kbuf_ff  <= '0;
         len_ff   <= '0;
         dot_ff   <= 1'b0;
         line_ff  <= '0;
         col_ff   <= '0;
         start_ff <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         kbuf_ff  <= kbuf_in;
         len_ff   <= len_in;
         dot_ff   <= dot_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         start_ff <= start_in;
      end
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      mode_ff == stt_pkg::MODE_NUMBER |-> len_ff <= NumMax && len_ff != 8'd0)
      else $error("number length out of range");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && end_of_input |=> mode_ff == stt_pkg::MODE_IDLE && line_ff == 16'd0 &&
      col_ff == 16'd0)
      else $error("end marker did not restart scanner");
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(col_ff) && $stable(line_ff))
      else $error("position moved without an item");
endmodule

### src/stt_out.sv
// ----------------------------------------------------------------------------
// stt_out: result registers
// Holds up to two tokens of one item and delivers them in order.
// ----------------------------------------------------------------------------
module stt_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic [1:0]         tok_count,
   input  stt_pkg::token_type tok0,
   input  stt_pkg::token_type tok1,
   output logic               can_load,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [47:0]        rsp_tdata,
   output logic               rsp_tlast
);
   logic [1:0]         cnt_ff, cnt_in;
   stt_pkg::token_type t0_ff, t0_in, t1_ff, t1_in;

   logic take;
   assign take = rsp_tvalid && rsp_tready;
   // next item may load when the buffer is empty or drains this cycle
   assign can_load = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_tready);
   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tlast = cnt_ff == 2'd1;
   assign rsp_tdata = {2'b00, t0_ff.len, t0_ff.col, t0_ff.line, t0_ff.kind};

   always_comb begin
      cnt_in = cnt_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      if (take) begin
         cnt_in = cnt_ff - 2'd1;
         t0_in = t1_ff;
      end
      if (load) begin
         cnt_in = tok_count;
         t0_in = tok0;
         t1_in = tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("result count overflow");
   a_load_ok: assert property (@(posedge clock) disable iff (reset) load |-> can_load)
      else $error("results overwritten");
   a_pair: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && rsp_tready && !load |=> cnt_ff == 2'd1)
      else $error("second token lost");
endmodule

### tb/sv/tb_source_text_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// Token checker for the source text tokenizer
// Watches the byte and token channels, predicts tokens and compares them.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_tokens
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] line;
      logic [15:0] col;
      logic [7:0]  len;
      logic        last;
   } exp_token_type;

   exp_token_type expected_tokens[$];

   stt_pkg::mode_type s_mode;
   logic [3:0]  s_op;
   logic [47:0] s_kwbuf;
   logic [7:0]  s_len;
   logic        s_dot;
   logic [15:0] s_line, s_col, s_start_line, s_start_col;
   int          n_new;

   function automatic logic [15:0] inc16(input logic [15:0] v);
      return (v == 16'hffff) ? v : v + 16'd1;
   endfunction

   function automatic logic alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic int op_slot(input logic [7:0] c);
      case (c)
         "+": return 0;
         "-": return 1;
         "*": return 2;
         "/": return 3;
         "%": return 4;
         "^": return 5;
         "=": return 6;
         "!": return 7;
         "~": return 8;
         "<": return 9;
         ">": return 10;
         default: return -1;
      endcase
   endfunction

   function automatic logic [5:0] single_kind(input logic [3:0] i);
      logic [5:0] t[11];
      t = '{6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd27, 6'd19, 6'd21, 6'd23, 6'd25};
      return t[i];
   endfunction

   function automatic logic [5:0] eq_kind(input logic [3:0] i);
      logic [5:0] t[11];
      t = '{6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd16, 6'd20, 6'd22, 6'd24, 6'd26};
      return t[i];
   endfunction

   function automatic int punct(input logic [7:0] c);
      case (c)
         "(": return 34;
         ")": return 35;
         "[": return 36;
         "]": return 37;
         "{": return 38;
         "}": return 39;
         ",": return 43;
         ";": return 44;
         ":": return 40;
         default: return -1;
      endcase
   endfunction

   function automatic logic [5:0] word_kind(input logic [47:0] b, input logic [7:0] n);
      if (n == 6 && b == 48'h72657475726e) return 6'd2;
      if (n == 2 && b == 48'h6966)         return 6'd3;
      if (n == 5 && b == 48'h7768696c65)   return 6'd4;
      if (n == 3 && b == 48'h666f72)       return 6'd5;
      if (n == 2 && b == 48'h666e)         return 6'd6;
      if (n == 3 && b == 48'h766172)       return 6'd7;
      if (n == 3 && b == 48'h6c6574)       return 6'd8;
      if (n == 5 && b == 48'h636f6e7374)   return 6'd9;
      return stt_pkg::KIND_ID;
   endfunction

   task automatic push_token(input logic [5:0] kind, input logic [7:0] len);
      expected_tokens.push_back({kind, s_start_line, s_start_col, len, 1'b0});
      n_new++;
   endtask

   task automatic close_token();
      case (s_mode)
         stt_pkg::MODE_IDENT:  push_token(word_kind(s_kwbuf, s_len), s_len);
         stt_pkg::MODE_NUMBER: push_token(stt_pkg::KIND_NUMBER, s_len);
         stt_pkg::MODE_OPER:   push_token(single_kind(s_op), 8'd1);
         default: ;
      endcase
      s_mode = stt_pkg::MODE_IDLE;
   endtask

   task automatic start_token(input logic [7:0] c);
      int k;
      if (c == " " || (c >= 9 && c <= 13)) begin
         if (c == 8'd10) begin
            s_line = inc16(s_line);
            s_col = '0;
         end else begin
            s_col = inc16(s_col);
         end
         return;
      end
      s_start_line = s_line;
      s_start_col = s_col;
      s_col = inc16(s_col);
      k = op_slot(c);
      if (alpha(c)) begin
         s_mode = stt_pkg::MODE_IDENT;
         s_len = 8'd1;
         s_kwbuf = {40'd0, c};
      end else if (digit(c) || c == ".") begin
         s_mode = stt_pkg::MODE_NUMBER;
         s_len = 8'd1;
         s_dot = (c == ".");
      end else if (k >= 0) begin
         s_mode = stt_pkg::MODE_OPER;
         s_op = k[3:0];
         s_len = 8'd1;
      end else if (punct(c) >= 0) begin
         k = punct(c);
         push_token(k[5:0], 8'd1);
      end else begin
         push_token(stt_pkg::KIND_UNKNOWN, 8'd1);
      end
   endtask

   task automatic clear_state();
      s_mode = stt_pkg::MODE_IDLE;
      s_op = '0;
      s_kwbuf = '0;
      s_len = '0;
      s_dot = 1'b0;
      s_line = '0;
      s_col = '0;
      s_start_line = '0;
      s_start_col = '0;
   endtask

   // advance the scanner by one byte and queue the tokens it yields
   task automatic scan_byte(input logic [7:0] c, input logic eoi);
      logic [5:0] k2;
      n_new = 0;
      if (eoi) begin
         close_token();
         s_start_line = s_line;
         s_start_col = s_col;
         push_token(stt_pkg::KIND_END, 8'd0);
         clear_state();
      end else if (s_mode == stt_pkg::MODE_IDENT) begin
         if (alpha(c) || digit(c)) begin
            if (s_len != 8'd255) s_len++;
            if (s_len <= 6) s_kwbuf = {s_kwbuf[39:0], c};
            s_col = inc16(s_col);
         end else begin
            close_token();
            start_token(c);
         end
      end else if (s_mode == stt_pkg::MODE_NUMBER) begin
         if (s_len < stt_pkg::MaxNumberLength && (digit(c) || (c == "." && !s_dot))) begin
            if (c == ".") s_dot = 1'b1;
            s_len++;
            s_col = inc16(s_col);
         end else begin
            close_token();
            start_token(c);
         end
      end else if (s_mode == stt_pkg::MODE_OPER) begin
         k2 = 6'h3f;
         if (c == "=") k2 = eq_kind(s_op);
         else if (s_op == stt_pkg::OP_PLUS && c == "+") k2 = stt_pkg::KIND_INC;
         else if (s_op == stt_pkg::OP_MINUS && c == "-") k2 = stt_pkg::KIND_DEC;
         else if (s_op == stt_pkg::OP_MINUS && c == ">") k2 = stt_pkg::KIND_ARROW_R;
         else if (s_op == stt_pkg::OP_LT && c == "-") k2 = stt_pkg::KIND_ARROW_L;
         if (k2 != 6'h3f) begin
            push_token(k2, 8'd2);
            s_col = inc16(s_col);
            s_mode = stt_pkg::MODE_IDLE;
         end else begin
            close_token();
            start_token(c);
         end
      end else begin
         start_token(c);
      end
      if (n_new > 0) expected_tokens[$].last = 1'b1;
   endtask

   exp_token_type got, want;

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_tokens.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[5:0], rsp_tdata[21:6], rsp_tdata[37:22], rsp_tdata[45:38],
                   rsp_tlast};
            if (expected_tokens.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected token: kind %0d line %0d col %0d len %0d last %0d",
                           got.kind, got.line, got.col, got.len, got.last);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_tokens.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("token mismatch: exp kind %0d line %0d col %0d len %0d last %0d",
                              want.kind, want.line, want.col, want.len, want.last,
                              " / got kind %0d line %0d col %0d len %0d last %0d",
                              got.kind, got.line, got.col, got.len, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tuser);
      end
      pending_tokens = expected_tokens.size();
   end
endmodule

### tb/sv/tb_source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// Testbench for the source text tokenizer
// Feeds directed and random source text under varied flow control.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [47:0] rsp_tdata;
   int          fail_count, pending_tokens;
   int          send_idle_pct, recv_stall_pct, hold_off;
   int          quiet_cycles;

   source_text_tokenizer uut (.*);

   tb_source_text_tokenizer_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: random stall, or a long hold-off when requested
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] c, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tuser <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i], 1'b0);
   endtask

   function automatic logic [7:0] pick_char(input int cls);
      string ops, pun, ws;
      ops = "+-*/%^=!~<>";
      pun = "()[]{},;:";
      ws = " \t\n\r";
      case (cls)
         0: return 8'($urandom_range(25)) + "a";
         1: return 8'($urandom_range(9)) + "0";
         2: return ops[$urandom_range(10)];
         3: return pun[$urandom_range(8)];
         4: return ws[$urandom_range(3)];
         5: return ".";
         6: return "_";
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic random_phase(input int n);
      string kw[8];
      int cls;
      kw = '{"return", "if", "while", "for", "fn", "var", "let", "const"};
      for (int i = 0; i < n; i++) begin
         cls = $urandom_range(99);
         if (cls < 8) send_text(kw[$urandom_range(7)]);
         else if (cls < 10) send_byte(8'd0, 1'b1);
         else if (cls < 85) send_byte(pick_char($urandom_range(6)), 1'b0);
         else if (cls < 95) send_byte(pick_char(2), 1'b0);
         else send_byte(pick_char(7), 1'b0);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_tokens != 0) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: keywords, near-keywords, all operator pairs, numbers, odd bytes
      send_text("return if while for fn var let const returns _x9 ");
      send_text("++ -- -> <- == != ~= <= >= += -= *= /= %= ^= + - * / % ^ = ! ~ < > ");
      send_text("()[]{},;: 1.2.3 . 07\n");
      send_byte(8'd0, 1'b0);
      send_byte(8'd255, 1'b0);
      send_byte(8'd128, 1'b0);
      send_byte(8'h41, 1'b1);
      for (int i = 0; i < 130; i++) send_byte("9", 1'b0);
      for (int i = 0; i < 260; i++) send_byte("q", 1'b0);
      send_byte(8'd0, 1'b1);
      drain();

      random_phase(200);
      send_idle_pct = 55;
      random_phase(150);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 55;
      random_phase(150);
      send_idle_pct = 23;
      recv_stall_pct = 23;
      random_phase(150);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 60;
      random_phase(100);
      recv_stall_pct = 10;
      random_phase(200);
      send_byte(8'd0, 1'b1);
      drain();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending_tokens == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
